/* rtl/core/led_bar_animation_sequencer_defines.svh */
// Assertion macros used by the checker file of the LED bar sequencer.
// No dependencies; include by bare file name.
`ifndef LED_BAR_ANIMATION_SEQUENCER_DEFINES_SVH
`define LED_BAR_ANIMATION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define LBAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define LBAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/lbas_pkg.sv */
// Shared types and constants for the LED bar animation sequencer.
// No dependencies.
package lbas_pkg;

	// Command codes carried in func
	localparam logic [2:0] FUNC_UPDATE = 3'd0;
	localparam logic [2:0] FUNC_DEPART = 3'd1;
	localparam logic [2:0] FUNC_ARRIVE = 3'd2;
	localparam logic [2:0] FUNC_GO_UP  = 3'd3;
	localparam logic [2:0] FUNC_GO_DN  = 3'd4;

	// Configuration register indexes
	localparam logic CFG_RUN_INTERVAL   = 1'b0;
	localparam logic CFG_BLINK_INTERVAL = 1'b1;

	localparam logic [15:0] RUN_INTERVAL_RST   = 16'd250;
	localparam logic [15:0] BLINK_INTERVAL_RST = 16'd250;

	localparam logic [7:0] ALL_ON  = 8'hFF;
	localparam logic [7:0] ALL_OFF = 8'h00;
	localparam logic [2:0] TOGGLES = 3'd6;

	// floor(t/500) = floor((t>>2)/125); for a 30-bit dividend the quotient by
	// 125 is (x * ceil(2^37/125)) >> 37 exactly.
	localparam logic [30:0] ALARM_RECIP = 31'd1099511628;
	localparam int          ALARM_SHIFT = 37;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_DEPART = 5'b00010,
		MODE_UP     = 5'b00100,
		MODE_DOWN   = 5'b01000,
		MODE_ARRIVE = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] now_ms;
		logic        alarm;
		logic        alarm_on;   // bit 0 of now_ms/500 is clear
	} item_t;

endpackage

/* rtl/core/lbas_front.sv */
// Input register and alarm phase stage of the LED bar sequencer.
// Depends on lbas_pkg.
module lbas_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           func,
	input  logic [31:0]          now_ms,
	input  logic                 alarm,
	output logic                 item_valid,
	input  logic                 item_ready,
	output lbas_pkg::item_t      item
);

	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [31:0] now_s1;
	logic        alarm_s1;
	logic        valid_s2;
	lbas_pkg::item_t item_s2;
	logic [60:0] prod;
	logic        adv_s1;
	logic        adv_s2;

	assign adv_s2   = !valid_s2 || item_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign prod = 61'(now_s1[31:2]) * 61'(lbas_pkg::ALARM_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			func_s1  <= func;
			now_s1   <= now_ms;
			alarm_s1 <= alarm;
		end
		if (adv_s2 && valid_s1) begin
			item_s2.func     <= func_s1;
			item_s2.now_ms   <= now_s1;
			item_s2.alarm    <= alarm_s1;
			item_s2.alarm_on <= !prod[lbas_pkg::ALARM_SHIFT];
		end
	end

	assign item_valid = valid_s2;
	assign item       = item_s2;

endmodule

/* rtl/core/lbas_anim.sv */
// Animation state, configuration registers and result register of the
// LED bar sequencer. Depends on lbas_pkg.
module lbas_anim (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            item_valid,
	output logic            item_ready,
	input  lbas_pkg::item_t item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      led_pattern
);

	logic [15:0]     run_interval_q;
	logic [15:0]     blink_interval_q;
	lbas_pkg::mode_t mode_q, mode_d;
	logic [2:0]      head_q, head_d;
	logic [31:0]     last_q, last_d;
	logic [2:0]      toggle_q, toggle_d;
	logic            out_valid_q;
	logic [7:0]      led_q;

	logic            take;
	logic            emit;
	logic [7:0]      pat;
	logic [31:0]     elapsed;
	logic            blink_due;
	logic            run_due;
	logic [2:0]      tc_next;
	logic            upward;
	logic [2:0]      tail1;
	logic [2:0]      tail2;
	logic [7:0]      comet;

	assign take       = item_valid && (!out_valid_q || out_ready);
	assign item_ready = !out_valid_q || out_ready;

	assign elapsed   = item.now_ms - last_q;
	assign blink_due = elapsed >= {16'd0, blink_interval_q};
	assign run_due   = elapsed >= {16'd0, run_interval_q};
	assign tc_next   = toggle_q + 3'd1;
	assign upward    = (mode_q == lbas_pkg::MODE_UP);
	assign tail1     = upward ? head_q - 3'd1 : head_q + 3'd1;
	assign tail2     = upward ? head_q - 3'd2 : head_q + 3'd2;
	assign comet     = (8'd1 << head_q) | (8'd1 << tail1) | (8'd1 << tail2);

	always_comb begin
		mode_d   = mode_q;
		head_d   = head_q;
		last_d   = last_q;
		toggle_d = toggle_q;
		emit     = 1'b0;
		pat      = lbas_pkg::ALL_OFF;
		case (item.func)
			lbas_pkg::FUNC_DEPART, lbas_pkg::FUNC_ARRIVE: begin
				mode_d   = (item.func == lbas_pkg::FUNC_DEPART) ?
					lbas_pkg::MODE_DEPART : lbas_pkg::MODE_ARRIVE;
				toggle_d = 3'd0;
				last_d   = item.now_ms;
				emit     = 1'b1;
				pat      = lbas_pkg::ALL_ON;
			end
			lbas_pkg::FUNC_GO_UP: begin
				mode_d = lbas_pkg::MODE_UP;
				head_d = 3'd0;
				last_d = item.now_ms;
			end
			lbas_pkg::FUNC_GO_DN: begin
				mode_d = lbas_pkg::MODE_DOWN;
				head_d = 3'd7;
				last_d = item.now_ms;
			end
			lbas_pkg::FUNC_UPDATE: begin
				if (item.alarm) begin
					// freeze the animation, flash at half the alarm period
					emit = 1'b1;
					pat  = item.alarm_on ? lbas_pkg::ALL_ON : lbas_pkg::ALL_OFF;
				end else begin
					case (mode_q)
						lbas_pkg::MODE_DEPART, lbas_pkg::MODE_ARRIVE: begin
							if (blink_due) begin
								emit     = 1'b1;
								last_d   = item.now_ms;
								toggle_d = tc_next;
								if (tc_next < lbas_pkg::TOGGLES) begin
									pat = tc_next[0] ? lbas_pkg::ALL_OFF : lbas_pkg::ALL_ON;
								end else begin
									pat = (mode_q == lbas_pkg::MODE_DEPART) ?
										lbas_pkg::ALL_ON : lbas_pkg::ALL_OFF;
									mode_d = lbas_pkg::MODE_IDLE;
								end
							end
						end
						lbas_pkg::MODE_UP, lbas_pkg::MODE_DOWN: begin
							if (run_due) begin
								emit   = 1'b1;
								last_d = item.now_ms;
								pat    = comet;
								head_d = upward ? head_q + 3'd1 : head_q - 3'd1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_interval_q   <= lbas_pkg::RUN_INTERVAL_RST;
			blink_interval_q <= lbas_pkg::BLINK_INTERVAL_RST;
			mode_q           <= lbas_pkg::MODE_IDLE;
			head_q           <= 3'd0;
			last_q           <= 32'd0;
			toggle_q         <= 3'd0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == lbas_pkg::CFG_RUN_INTERVAL)
					run_interval_q <= cfg_data;
				else
					blink_interval_q <= cfg_data;
			end
			if (take) begin
				mode_q      <= mode_d;
				head_q      <= head_d;
				last_q      <= last_d;
				toggle_q    <= toggle_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit)
			led_q <= pat;
	end

	assign out_valid   = out_valid_q;
	assign led_pattern = led_q;

endmodule

/* rtl/core/led_bar_animation_sequencer.sv */
// LED bar animation sequencer: takes one word per clock while in_ready is
// high and returns at most one LED pattern word per input word. The first
// stage registers the input on the accepting edge, the second holds the
// alarm phase taken from a 30 by 31 bit reciprocal multiply (now_ms/500),
// and the third applies the word to the animation state and loads the
// result register. Words that cause no pattern leave no result.
// Depends on lbas_pkg, lbas_front and lbas_anim.
module led_bar_animation_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] now_ms,
	input  logic        alarm,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  led_pattern
);

	logic            item_valid;
	logic            item_ready;
	lbas_pkg::item_t item;

	lbas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.now_ms     (now_ms),
		.alarm      (alarm),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	lbas_anim u_anim (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.led_pattern (led_pattern)
	);

endmodule

/* rtl/core/lbas_checker.sv */
// Port-level checks for the LED bar sequencer, bound to the top level.
// Depends on led_bar_animation_sequencer_defines.svh.
`include "led_bar_animation_sequencer_defines.svh"

module lbas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  led_pattern
);

	// hold a stalled result word
	`LBAS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`LBAS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(led_pattern))
	// an empty result register never blocks the input
	`LBAS_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	// only all-off, all-on or a three-lamp comet can appear
	`LBAS_ASSERT_IMPLY(a_pattern_shape, clk, arst_n, out_valid,
		$countones(led_pattern) == 0 || $countones(led_pattern) == 3 ||
		$countones(led_pattern) == 8)

endmodule

bind led_bar_animation_sequencer lbas_checker u_lbas_checker (.*);
